/* rtl/sqmm_pkg.sv */
package sqmm_pkg;

    localparam int WORD_W = 32;
    localparam int COL_W  = 3;

    typedef logic [WORD_W-1:0] word_t;

    // Opcode values of the input request.
    localparam logic OP_LOAD_B = 1'b0;
    localparam logic OP_A      = 1'b1;

    // Control that travels with each request along the chain.
    typedef struct packed {
        logic valid;
        logic is_a;
        logic row_end;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_WAIT,
        ST_DRAIN
    } state_t;

endpackage

/* rtl/square_integer_matrix_multiply_unit.sv */
// Output: a row of C starts to appear once its last A element has passed along the
// chain and the last cell has captured its sum, then gives one element per cycle while m_ready is high.
// Throughput: one request per cycle for B loads and A elements within a row; the input
// stalls from the last A element of a row until its DIM results have been taken.
// Reset: aresetn, synchronous and active low, clears control state and accumulators;
// the stored B matrix is left undefined until it is loaded.
module square_integer_matrix_multiply_unit
    import sqmm_pkg::*;
#(
    parameter int DIM = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_opcode,
    input  logic signed [31:0] s_element,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_sum,
    output logic [2:0]         m_column,
    output logic               m_last
);

    // Width of a row or column index within the matrix.
    localparam int IDX_W = (DIM > 1) ? $clog2(DIM) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIM - 1);

    // Position counters. B is loaded row-major, so the column counter runs fastest and
    // the row counter steps each time a row of B wraps.
    logic [IDX_W-1:0] b_row_reg, b_row_next;
    logic [IDX_W-1:0] b_col_reg, b_col_next;
    logic [IDX_W-1:0] a_col_reg, a_col_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;

    state_t state_reg, state_next;

    // Request register that feeds the head of the cell chain.
    cell_ctrl_t       head_ctrl_reg, head_ctrl_next;
    word_t            head_data_reg;
    logic [IDX_W-1:0] head_row_reg, head_row_next;
    logic [IDX_W-1:0] head_col_reg;

    logic accept;
    logic is_a;
    logic a_row_end;
    logic shift;
    logic [IDX_W+2:0] col_ext;

    // Chain wiring: element i feeds cell i; results shift from cell i+1 into cell i, so
    // cell 0 always presents the next column of the finished row.
    cell_ctrl_t       ctrl_chain [DIM+1];
    word_t            data_chain [DIM+1];
    logic [IDX_W-1:0] row_chain  [DIM+1];
    logic [IDX_W-1:0] col_chain  [DIM+1];
    word_t            res_chain  [DIM+1];
    logic [DIM-1:0]   cap_vec;

    assign accept    = s_valid && s_ready;
    assign is_a      = (s_opcode == OP_A);
    assign a_row_end = (a_col_reg == LAST_IDX);

    always_comb begin
        b_row_next = b_row_reg;
        b_col_next = b_col_reg;
        a_col_next = a_col_reg;
        if (accept) begin
            if (!is_a) begin
                if (b_col_reg == LAST_IDX) begin
                    b_col_next = '0;
                    b_row_next = (b_row_reg == LAST_IDX) ? '0 : b_row_reg + 1'b1;
                end else begin
                    b_col_next = b_col_reg + 1'b1;
                end
            end else begin
                a_col_next = a_row_end ? '0 : a_col_reg + 1'b1;
            end
        end
    end

    // A B load carries its row and column; an A element carries its column within the
    // row of A, which is the row of B that it is multiplied with.
    always_comb begin
        head_ctrl_next.valid   = accept;
        head_ctrl_next.is_a    = is_a;
        head_ctrl_next.row_end = is_a && a_row_end;
        head_row_next          = is_a ? a_col_reg : b_row_reg;
    end

    // Next state. The input is held off from the end of a row until the whole row of C
    // has been delivered, so captured sums are never overwritten while waiting.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_RUN: begin
                if (accept && is_a && a_row_end) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (cap_vec[DIM-1]) begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                end
            end
            ST_DRAIN: begin
                if (m_ready) begin
                    if (cnt_reg == LAST_IDX) begin
                        state_next = ST_RUN;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_RUN;
                cnt_next   = '0;
            end
        endcase
    end

    // Outputs of the controller.
    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ST_RUN:   s_ready = 1'b1;
            ST_WAIT:  s_ready = 1'b0;
            ST_DRAIN: m_valid = 1'b1;
            default: begin
                s_ready = 1'b0;
                m_valid = 1'b0;
            end
        endcase
    end

    assign shift    = m_valid && m_ready;
    assign col_ext  = {3'b000, cnt_reg};
    assign m_column = col_ext[2:0];
    assign m_last   = (cnt_reg == LAST_IDX);
    assign m_sum    = signed'(res_chain[0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_RUN;
            cnt_reg       <= '0;
            b_row_reg     <= '0;
            b_col_reg     <= '0;
            a_col_reg     <= '0;
            head_ctrl_reg <= '0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            b_row_reg     <= b_row_next;
            b_col_reg     <= b_col_next;
            a_col_reg     <= a_col_next;
            head_ctrl_reg <= head_ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_data_reg <= word_t'(s_element);
        head_row_reg  <= head_row_next;
        head_col_reg  <= b_col_reg;
    end

    assign ctrl_chain[0] = head_ctrl_reg;
    assign data_chain[0] = head_data_reg;
    assign row_chain[0]  = head_row_reg;
    assign col_chain[0]  = head_col_reg;
    assign res_chain[DIM] = '0;

    // Each cell holds one column of B and one accumulator of the current row of C.
    for (genvar i = 0; i < DIM; i++) begin : g_cell
        sqmm_cell #(
            .DIM      (DIM),
            .CELL_IDX (i),
            .IDX_W    (IDX_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl_in  (ctrl_chain[i]),
            .data_in  (data_chain[i]),
            .row_in   (row_chain[i]),
            .col_in   (col_chain[i]),
            .ctrl_out (ctrl_chain[i+1]),
            .data_out (data_chain[i+1]),
            .row_out  (row_chain[i+1]),
            .col_out  (col_chain[i+1]),
            .res_in   (res_chain[i+1]),
            .shift    (shift),
            .res_out  (res_chain[i]),
            .capture  (cap_vec[i])
        );
    end

endmodule

/* rtl/sqmm_cell.sv */
module sqmm_cell
    import sqmm_pkg::*;
#(
    parameter int DIM      = 8,
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = 3
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cell_ctrl_t       ctrl_in,
    input  word_t            data_in,
    input  logic [IDX_W-1:0] row_in,
    input  logic [IDX_W-1:0] col_in,
    output cell_ctrl_t       ctrl_out,
    output word_t            data_out,
    output logic [IDX_W-1:0] row_out,
    output logic [IDX_W-1:0] col_out,
    input  word_t            res_in,
    input  logic             shift,
    output word_t            res_out,
    output logic             capture
);

    // One column of B: entry r holds B[r][CELL_IDX].
    word_t b_mem [DIM];

    cell_ctrl_t       ctrl_reg;
    word_t            data_reg;
    logic [IDX_W-1:0] row_reg;
    logic [IDX_W-1:0] col_reg;

    logic  v1_reg, end1_reg;
    word_t a1_reg, b1_reg;
    logic  v2_reg, end2_reg;
    word_t prod_reg;
    word_t acc_reg, acc_next;
    word_t res_reg, res_next;
    word_t sum;

    logic [2*WORD_W-1:0] prod_full;

    logic wr_en, rd_en;

    assign wr_en = ctrl_in.valid && !ctrl_in.is_a && (col_in == IDX_W'(CELL_IDX));
    assign rd_en = ctrl_in.valid && ctrl_in.is_a;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            b_mem[row_in] <= data_in;
        end
        if (rd_en) begin
            b1_reg <= b_mem[row_in];
        end
    end

    assign prod_full = a1_reg * b1_reg;
    assign sum       = acc_reg + prod_reg;
    assign capture   = v2_reg && end2_reg;

    always_comb begin
        acc_next = acc_reg;
        res_next = res_reg;
        if (v2_reg) begin
            if (end2_reg) begin
                acc_next = '0;
                res_next = sum;
            end else begin
                acc_next = sum;
            end
        end else if (shift) begin
            res_next = res_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            acc_reg  <= '0;
        end else begin
            ctrl_reg <= ctrl_in;
            v1_reg   <= rd_en;
            v2_reg   <= v1_reg;
            acc_reg  <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_in;
        row_reg  <= row_in;
        col_reg  <= col_in;
        a1_reg   <= data_in;
        end1_reg <= ctrl_in.row_end;
        end2_reg <= end1_reg;
        prod_reg <= prod_full[WORD_W-1:0];
        res_reg  <= res_next;
    end

    assign ctrl_out = ctrl_reg;
    assign data_out = data_reg;
    assign row_out  = row_reg;
    assign col_out  = col_reg;
    assign res_out  = res_reg;

endmodule
